[hdl/qnl_pkg.sv]
// qnl_pkg: widths, stage indices and types shared by the quaternion nlerp block.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package qnl_pkg;

    localparam int COMP_W   = 16;                  // quaternion component, Q2.14
    localparam int BLEND_W  = 16;                  // blend weight, Q0.16
    localparam int FRAC_W   = COMP_W - 2;
    localparam int LANES    = 4;                   // x, y, z, w
    localparam int PROD_W   = 2 * COMP_W;          // a*b
    localparam int DOT_W    = PROD_W + 2;          // sum of four products
    localparam int MUL_W    = COMP_W + BLEND_W + 2;// weighted component product
    localparam int MAG_W    = COMP_W + BLEND_W;    // |c| <= 2^31
    localparam int SQ_W     = 2 * MAG_W;
    localparam int SUM_W    = SQ_W + 1;
    localparam int ROOT_W   = COMP_W;              // ratio root, 0 .. 2^(COMP_W-1)
    localparam int REM_W    = SUM_W + 2 * ROOT_W;
    localparam int LSH      = 2 * FRAC_W + 2;      // c^2 scale before the root

    // valid-bit index of each pipeline register
    localparam int ST_ROOT0 = 5;
    localparam int ST_OUT   = ST_ROOT0 + ROOT_W + 1;
    localparam int N_ST     = ST_OUT + 1;

    typedef logic signed [COMP_W-1:0] t_comp;
    typedef logic        [BLEND_W-1:0] t_blend;
    typedef logic        [REM_W-1:0]   t_rem;
    typedef logic        [SUM_W-1:0]   t_sum;
    typedef logic        [ROOT_W-1:0]  t_root;

endpackage

`default_nettype wire

[hdl/qnl_if.sv]
// qnl_in_if / qnl_out_if: valid-ready channels of the quaternion nlerp block.
// Depends on qnl_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface qnl_in_if;
    logic             valid;
    logic             ready;
    qnl_pkg::t_comp   first_x;
    qnl_pkg::t_comp   first_y;
    qnl_pkg::t_comp   first_z;
    qnl_pkg::t_comp   first_w;
    qnl_pkg::t_comp   second_x;
    qnl_pkg::t_comp   second_y;
    qnl_pkg::t_comp   second_z;
    qnl_pkg::t_comp   second_w;
    qnl_pkg::t_blend  blend;

    modport source (output valid, first_x, first_y, first_z, first_w,
                    second_x, second_y, second_z, second_w, blend, input ready);
    modport sink   (input valid, first_x, first_y, first_z, first_w,
                    second_x, second_y, second_z, second_w, blend, output ready);
endinterface

interface qnl_out_if;
    logic             valid;
    logic             ready;
    qnl_pkg::t_comp   out_x;
    qnl_pkg::t_comp   out_y;
    qnl_pkg::t_comp   out_z;
    qnl_pkg::t_comp   out_w;
    logic             degenerate;
    logic             flipped;

    modport source (output valid, out_x, out_y, out_z, out_w, degenerate, flipped,
                    input ready);
    modport sink   (input valid, out_x, out_y, out_z, out_w, degenerate, flipped,
                    output ready);
endinterface

`default_nettype wire

[hdl/quaternion_nlerp.sv]
// quaternion_nlerp: shortest-path normalized lerp of two Q2.14 quaternions.
// Depends on qnl_pkg and the channel interfaces in qnl_if.sv.
//
//   channel  dir  handshake     beat contents
//   i_in     in   valid/ready   first_{x,y,z,w}, second_{x,y,z,w}, blend
//   o_out    out  valid/ready   out_{x,y,z,w}, degenerate, flipped
//
// One beat in and one beat out per cycle while o_out.ready is high.
// Six arithmetic stages (dot product, flip, weighting, blend, square, norm sum)
// then one stage per bit of a 16-bit restoring root of c^2*2^30/S, then output.
// Reset clears the valid bits only. Each stage holds while the one after it is
// full and stalled, so empty stages close up and no beat is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_nlerp (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    qnl_in_if.sink     i_in,
    qnl_out_if.source  o_out
);

    logic [qnl_pkg::N_ST-1:0] r_vld;
    logic [qnl_pkg::N_ST-1:0] en;

    // stage 0: dot products
    qnl_pkg::t_comp                       r0_a [qnl_pkg::LANES];
    qnl_pkg::t_comp                       r0_b [qnl_pkg::LANES];
    logic signed [qnl_pkg::PROD_W-1:0]    r0_p [qnl_pkg::LANES];
    qnl_pkg::t_blend                      r0_l;
    // stage 1: sign test and flip
    qnl_pkg::t_comp                       r1_a  [qnl_pkg::LANES];
    logic signed [qnl_pkg::COMP_W:0]      r1_bb [qnl_pkg::LANES];
    qnl_pkg::t_blend                      r1_l;
    logic                                 r1_neg;
    // stage 2: weighted products
    logic signed [qnl_pkg::MUL_W-1:0]     r2_pa [qnl_pkg::LANES];
    logic signed [qnl_pkg::MUL_W-1:0]     r2_pb [qnl_pkg::LANES];
    logic                                 r2_neg;
    // stage 3: blended magnitude
    logic [qnl_pkg::MAG_W-1:0]            r3_mag [qnl_pkg::LANES];
    logic [qnl_pkg::LANES-1:0]            r3_sgn;
    logic                                 r3_neg;
    // stage 4: squares
    logic [qnl_pkg::SQ_W-1:0]             r4_sq [qnl_pkg::LANES];
    logic [qnl_pkg::LANES-1:0]            r4_sgn;
    logic                                 r4_neg;
    // root stages: index 0 is the initial state, k+1 after bit k
    qnl_pkg::t_rem   r_rem  [qnl_pkg::ROOT_W+1][qnl_pkg::LANES];
    qnl_pkg::t_rem   r_prod [qnl_pkg::ROOT_W+1][qnl_pkg::LANES];
    qnl_pkg::t_root  r_root [qnl_pkg::ROOT_W+1][qnl_pkg::LANES];
    qnl_pkg::t_sum   r_sum  [qnl_pkg::ROOT_W+1];
    logic [qnl_pkg::LANES-1:0] r_sgn [qnl_pkg::ROOT_W+1];
    logic [qnl_pkg::ROOT_W:0]  r_zero;
    logic [qnl_pkg::ROOT_W:0]  r_neg;
    // output register
    qnl_pkg::t_comp  r_res [qnl_pkg::LANES];
    logic            r_deg;
    logic            r_flip;

    qnl_pkg::t_comp  in_a [qnl_pkg::LANES];
    qnl_pkg::t_comp  in_b [qnl_pkg::LANES];

    qnl_pkg::t_rem   n_rem  [qnl_pkg::ROOT_W][qnl_pkg::LANES];
    qnl_pkg::t_rem   n_prod [qnl_pkg::ROOT_W][qnl_pkg::LANES];
    qnl_pkg::t_root  n_root [qnl_pkg::ROOT_W][qnl_pkg::LANES];

    assign in_a[0] = i_in.first_x;
    assign in_a[1] = i_in.first_y;
    assign in_a[2] = i_in.first_z;
    assign in_a[3] = i_in.first_w;
    assign in_b[0] = i_in.second_x;
    assign in_b[1] = i_in.second_y;
    assign in_b[2] = i_in.second_z;
    assign in_b[3] = i_in.second_w;

    // a stage may load when it is empty or its content moves on
    always_comb begin
        en[qnl_pkg::N_ST-1] = !r_vld[qnl_pkg::N_ST-1] || o_out.ready;
        for (int k = qnl_pkg::N_ST - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_in.ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k < qnl_pkg::N_ST; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 0
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int i = 0; i < qnl_pkg::LANES; i++) begin
                r0_a[i] <= in_a[i];
                r0_b[i] <= in_b[i];
                r0_p[i] <= in_a[i] * in_b[i];
            end
            r0_l <= i_in.blend;
        end
    end

    // stage 1: a zero dot product does not flip
    logic signed [qnl_pkg::DOT_W-1:0] dot;
    logic                             dot_neg;

    always_comb begin
        dot = '0;
        for (int i = 0; i < qnl_pkg::LANES; i++) begin
            dot = dot + qnl_pkg::DOT_W'(r0_p[i]);
        end
        dot_neg = dot[qnl_pkg::DOT_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            for (int i = 0; i < qnl_pkg::LANES; i++) begin
                r1_a[i]  <= r0_a[i];
                r1_bb[i] <= dot_neg ? -(qnl_pkg::COMP_W+1)'(r0_b[i])
                                    :  (qnl_pkg::COMP_W+1)'(r0_b[i]);
            end
            r1_l   <= r0_l;
            r1_neg <= dot_neg;
        end
    end

    // stage 2: a*(1-l) and b'*l
    logic signed [qnl_pkg::MUL_W-1:0] w_first;
    logic signed [qnl_pkg::MUL_W-1:0] w_second;

    always_comb begin
        w_second = $signed(qnl_pkg::MUL_W'(r1_l));
        w_first  = $signed(qnl_pkg::MUL_W'(1) << qnl_pkg::BLEND_W) - w_second;
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            for (int i = 0; i < qnl_pkg::LANES; i++) begin
                r2_pa[i] <= qnl_pkg::MUL_W'(r1_a[i]) * w_first;
                r2_pb[i] <= qnl_pkg::MUL_W'(r1_bb[i]) * w_second;
            end
            r2_neg <= r1_neg;
        end
    end

    // stage 3
    logic signed [qnl_pkg::MUL_W-1:0] blended [qnl_pkg::LANES];

    always_comb begin
        for (int i = 0; i < qnl_pkg::LANES; i++) begin
            blended[i] = r2_pa[i] + r2_pb[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            for (int i = 0; i < qnl_pkg::LANES; i++) begin
                r3_mag[i] <= blended[i][qnl_pkg::MUL_W-1]
                           ? qnl_pkg::MAG_W'(-blended[i])
                           : qnl_pkg::MAG_W'(blended[i]);
                r3_sgn[i] <= blended[i][qnl_pkg::MUL_W-1];
            end
            r3_neg <= r2_neg;
        end
    end

    // stage 4
    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            for (int i = 0; i < qnl_pkg::LANES; i++) begin
                r4_sq[i] <= qnl_pkg::SQ_W'(r3_mag[i]) * qnl_pkg::SQ_W'(r3_mag[i]);
            end
            r4_sgn <= r3_sgn;
            r4_neg <= r3_neg;
        end
    end

    // stage 5: norm sum and scaled squares seed the root
    qnl_pkg::t_sum sq_sum;

    always_comb begin
        sq_sum = '0;
        for (int i = 0; i < qnl_pkg::LANES; i++) begin
            sq_sum = sq_sum + qnl_pkg::SUM_W'(r4_sq[i]);
        end
    end

    // root bit j: largest v with v^2*S <= c^2*2^30; rem = L - v^2*S, prod = v*S
    always_comb begin
        qnl_pkg::t_rem trial;
        for (int k = 0; k < qnl_pkg::ROOT_W; k++) begin
            for (int i = 0; i < qnl_pkg::LANES; i++) begin
                trial = (r_prod[k][i] << (qnl_pkg::ROOT_W - k))
                      + (qnl_pkg::REM_W'(r_sum[k]) << (2 * (qnl_pkg::ROOT_W - 1 - k)));
                if (r_rem[k][i] >= trial) begin
                    n_rem[k][i]  = r_rem[k][i] - trial;
                    n_prod[k][i] = r_prod[k][i]
                                 + (qnl_pkg::REM_W'(r_sum[k]) << (qnl_pkg::ROOT_W - 1 - k));
                    n_root[k][i] = r_root[k][i]
                                 | (qnl_pkg::t_root'(1) << (qnl_pkg::ROOT_W - 1 - k));
                end else begin
                    n_rem[k][i]  = r_rem[k][i];
                    n_prod[k][i] = r_prod[k][i];
                    n_root[k][i] = r_root[k][i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[qnl_pkg::ST_ROOT0]) begin
            for (int i = 0; i < qnl_pkg::LANES; i++) begin
                r_rem[0][i]  <= qnl_pkg::REM_W'(r4_sq[i]) << qnl_pkg::LSH;
                r_prod[0][i] <= '0;
                r_root[0][i] <= '0;
            end
            r_sum[0]  <= sq_sum;
            r_sgn[0]  <= r4_sgn;
            r_zero[0] <= (sq_sum == '0);
            r_neg[0]  <= r4_neg;
        end
        for (int k = 0; k < qnl_pkg::ROOT_W; k++) begin
            if (en[qnl_pkg::ST_ROOT0 + 1 + k]) begin
                for (int i = 0; i < qnl_pkg::LANES; i++) begin
                    r_rem[k+1][i]  <= n_rem[k][i];
                    r_prod[k+1][i] <= n_prod[k][i];
                    r_root[k+1][i] <= n_root[k][i];
                end
                r_sum[k+1]  <= r_sum[k];
                r_sgn[k+1]  <= r_sgn[k];
                r_zero[k+1] <= r_zero[k];
                r_neg[k+1]  <= r_neg[k];
            end
        end
    end

    // output: rounded result is (v+1)/2, the last odd v' <= v over two
    logic [qnl_pkg::ROOT_W:0] half_up [qnl_pkg::LANES];

    always_comb begin
        for (int i = 0; i < qnl_pkg::LANES; i++) begin
            half_up[i] = ((qnl_pkg::ROOT_W+1)'(r_root[qnl_pkg::ROOT_W][i])
                         + (qnl_pkg::ROOT_W+1)'(1)) >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[qnl_pkg::ST_OUT]) begin
            for (int i = 0; i < qnl_pkg::LANES; i++) begin
                if (r_zero[qnl_pkg::ROOT_W]) begin
                    r_res[i] <= (i == qnl_pkg::LANES - 1)
                              ? qnl_pkg::t_comp'(1) << qnl_pkg::FRAC_W : '0;
                end else if (r_sgn[qnl_pkg::ROOT_W][i]) begin
                    r_res[i] <= -qnl_pkg::t_comp'(half_up[i]);
                end else begin
                    r_res[i] <= qnl_pkg::t_comp'(half_up[i]);
                end
            end
            r_deg  <= r_zero[qnl_pkg::ROOT_W];
            r_flip <= r_neg[qnl_pkg::ROOT_W];
        end
    end

    assign o_out.valid      = r_vld[qnl_pkg::ST_OUT];
    assign o_out.out_x      = r_res[0];
    assign o_out.out_y      = r_res[1];
    assign o_out.out_z      = r_res[2];
    assign o_out.out_w      = r_res[3];
    assign o_out.degenerate = r_deg;
    assign o_out.flipped    = r_flip;

endmodule

`default_nettype wire

[tb/quaternion_nlerp_test.sv]
// quaternion_nlerp_test: self-checking bench for the shortest-path quaternion nlerp.
// Depends on qnl_pkg, qnl_if.sv and quaternion_nlerp; random beats checked against
// an exact fixed-point blend-and-normalise predictor.
`timescale 1ns / 1ps

module quaternion_nlerp_test;

    typedef struct packed {
        qnl_pkg::t_comp a_x, a_y, a_z, a_w;
        qnl_pkg::t_comp b_x, b_y, b_z, b_w;
        qnl_pkg::t_blend lam;
    } t_pair;

    typedef struct packed {
        qnl_pkg::t_comp x, y, z, w;
        logic degen;
        logic flip;
    } t_rot;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    qnl_in_if  in_ch();
    qnl_out_if out_ch();

    quaternion_nlerp dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #2 i_clk = ~i_clk;

    t_pair pending_pairs[$];
    t_rot  blended_rots[$];
    int    fails = 0;
    bit    stim_done = 0;
    bit    long_hold = 0;       // forced receiver stall
    int    rx_gap = 0;          // receiver idle cycles still to go
    bit    drain_pause = 0;     // sender waits until nothing is outstanding

    // round(|c| * 2^FRAC / sqrt(S)), ties away from zero, by binary search
    function automatic longint unsigned scaled_mag(longint unsigned cm,
                                                   logic [127:0] sum);
        logic [191:0] lhs, rhs;
        longint unsigned lo, hi, mid, odd;
        lhs = ({128'd0, cm} * cm) << qnl_pkg::LSH;
        lo = 0;
        hi = 64'd1 << qnl_pkg::FRAC_W;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            odd = 2 * mid + 1;
            rhs = {128'd0, odd} * odd * sum;
            if (lhs >= rhs) lo = mid + 1;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic t_rot blend_pair(t_pair p);
        longint a[4], b[4], c[4], dot, lam, m;
        logic [127:0] sum;
        t_rot r;
        bit neg, zero;
        a = '{p.a_x, p.a_y, p.a_z, p.a_w};
        b = '{p.b_x, p.b_y, p.b_z, p.b_w};
        lam = p.lam;
        dot = 0;
        for (int i = 0; i < 4; i++) dot += a[i] * b[i];
        neg = dot < 0;
        sum = 0;
        zero = 1;
        for (int i = 0; i < 4; i++) begin
            c[i] = a[i] * ((64'sd1 << qnl_pkg::BLEND_W) - lam)
                 + (neg ? -b[i] : b[i]) * lam;
            m = c[i] < 0 ? -c[i] : c[i];
            if (m != 0) zero = 0;
            sum += 128'(m) * 128'(m);
        end
        if (zero) begin
            r.x = 0; r.y = 0; r.z = 0; r.w = qnl_pkg::t_comp'(1 << qnl_pkg::FRAC_W);
        end else begin
            for (int i = 0; i < 4; i++) begin
                m = scaled_mag(c[i] < 0 ? -c[i] : c[i], sum);
                c[i] = c[i] < 0 ? -m : m;
            end
            r.x = qnl_pkg::t_comp'(c[0]); r.y = qnl_pkg::t_comp'(c[1]);
            r.z = qnl_pkg::t_comp'(c[2]); r.w = qnl_pkg::t_comp'(c[3]);
        end
        r.degen = zero;
        r.flip = neg;
        return r;
    endfunction

    function automatic qnl_pkg::t_comp rand_comp();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return qnl_pkg::t_comp'($urandom_range(0, 6) - 3);
            3: return qnl_pkg::t_comp'(($urandom_range(0, 1) ? 1 : -1) * 16384);
            default: return qnl_pkg::t_comp'($urandom);
        endcase
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // driver
    int send_gap = 0;
    int sent = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid) sent <= sent + 1;
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                in_ch.valid <= 1'b0;
            end else if (pending_pairs.size() != 0 &&
                         !(drain_pause && blended_rots.size() != 0)) begin
                t_pair p;
                p = pending_pairs.pop_front();
                blended_rots.push_back(blend_pair(p));
                {in_ch.first_x, in_ch.first_y, in_ch.first_z, in_ch.first_w,
                 in_ch.second_x, in_ch.second_y, in_ch.second_z, in_ch.second_w,
                 in_ch.blend} <= p;
                in_ch.valid <= 1'b1;
                send_gap <= gap_len();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor and receiver back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                t_rot got, want;
                got = '{out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.out_w,
                        out_ch.degenerate, out_ch.flipped};
                if (blended_rots.size() == 0) begin
                    $display("%0t: unexpected beat %p", $realtime, got);
                    fails++;
                end else begin
                    want = blended_rots.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected %p actual %p",
                                 $realtime, want, got);
                        fails++;
                    end
                end
            end
            if (long_hold) begin
                out_ch.ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if (!stim_done) rx_gap <= gap_len();
            end
        end
    end

    initial begin
        t_pair p;
        in_ch.valid = 0;
        {in_ch.first_x, in_ch.first_y, in_ch.first_z, in_ch.first_w,
         in_ch.second_x, in_ch.second_y, in_ch.second_z, in_ch.second_w,
         in_ch.blend} = '0;
        out_ch.ready = 0;
        // directed: identity, zero norm, extremes, flip, zero dot, blend limits
        pending_pairs.push_back('{0, 0, 0, 16384, 0, 0, 0, 16384, 0});
        pending_pairs.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 16'h1234});
        pending_pairs.push_back('{1, 2, 3, 4, -1, -2, -3, -4, 16'h8000});
        pending_pairs.push_back('{16384, 0, 0, 0, 0, 16384, 0, 0, 16'h8000});
        pending_pairs.push_back('{0, 0, 0, 16384, 0, 0, 0, -16384, 16'hffff});
        pending_pairs.push_back('{0, 0, 0, 16384, 0, 0, 0, -16384, 16'h0000});
        pending_pairs.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                                  16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'hffff});
        pending_pairs.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                                  16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'h0001});
        pending_pairs.push_back('{16'sh7fff, 0, 16'sh8000, 1, 16'sh8000, 16'sh7fff,
                                  -1, 0, 16'h8000});
        pending_pairs.push_back('{1, 0, 0, 0, 0, 0, 0, 0, 0});
        pending_pairs.push_back('{1, 0, 0, 0, 1, 0, 0, 0, 16'hffff});
        pending_pairs.push_back('{2, 0, 0, 0, -1, 0, 0, 0, 16'h5555});
        pending_pairs.push_back('{3, 4, 0, 0, -4, 3, 0, 0, 16'haaaa});
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < 1100; i++) begin
            p = '{rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                  rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                  qnl_pkg::t_blend'($urandom_range(0, 7) == 0 ?
                           ($urandom_range(0, 1) ? 16'hffff : 0) : $urandom)};
            if ($urandom_range(0, 9) == 0) begin
                // negated second operand: exercises the flip, which undoes the negation
                p.b_x = -p.a_x; p.b_y = -p.a_y; p.b_z = -p.a_z; p.b_w = -p.a_w;
            end
            pending_pairs.push_back(p);
        end
        // long receiver stall while the sender keeps offering beats
        wait (sent > 300);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (80) @(posedge i_clk);
        long_hold <= 1'b0;
        wait (sent > 600);
        @(posedge i_clk);
        drain_pause <= 1'b1;
        wait (blended_rots.size() == 0);
        @(posedge i_clk);
        drain_pause <= 1'b0;
        wait (pending_pairs.size() == 0 && !in_ch.valid);
        stim_done = 1;
        wait (blended_rots.size() == 0);
        repeat (40) @(posedge i_clk);
        if (fails == 0)
            $display("quaternion_nlerp regression: pass");
        else
            $display("quaternion_nlerp regression: fail");
        $finish;
    end

    initial begin
        #2000000;
        $display("quaternion_nlerp regression: fail");
        $finish;
    end
endmodule
